// ===== hdl/afhq_pkg.sv =====
package afhq_pkg;

  localparam int CheckSlotsDefault = 3;

  localparam int CfgIdxW = 3;
  localparam int TimeW   = 64;
  localparam int ErrW    = 32;
  localparam int WaitW   = 5;
  localparam int AxisW   = 12;
  localparam int AxisLsb = 4;

  localparam logic [WaitW-1:0] GoodWaitFrames   = WaitW'(20);
  localparam logic [TimeW-1:0] ResetHoldoffUs   = TimeW'(10000);
  localparam logic [TimeW-1:0] RewriteHoldoffUs = TimeW'(3000);

  localparam int SlotChipId = 0;
  localparam int SlotConf   = 1;
  localparam int SlotRange  = 2;

  typedef enum logic [2:0] {
    StHeld       = 3'd0,
    StXferFail   = 3'd1,
    StDuplicate  = 3'd2,
    StAllZero    = 3'd3,
    StSuppressed = 3'd4,
    StValid      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FixNone      = 2'd0,
    FixSoftReset = 2'd1,
    FixRewrite   = 2'd2
  } fix_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgChipId      = 3'd0,
    CfgConf        = 3'd1,
    CfgRange       = 3'd2,
    CfgNewDataMask = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [TimeW-1:0] now_us;
    logic             transfer_ok;
    logic [7:0]       x_low;
    logic [7:0]       x_high;
    logic [7:0]       y_low;
    logic [7:0]       y_high;
    logic [7:0]       z_low;
    logic [7:0]       z_high;
    logic [7:0]       check_readback;
  } frame_t;

  typedef struct packed {
    status_e                 status;
    logic signed [AxisW-1:0] accel_x;
    logic signed [AxisW-1:0] accel_y;
    logic signed [AxisW-1:0] accel_z;
    fix_e                    fix_action;
    logic [1:0]              fix_slot;
    logic [7:0]              fix_value;
    logic [ErrW-1:0]         error_total;
    logic [1:0]              next_slot;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [7:0]         data;
  } cfg_t;

endpackage

// ===== hdl/afhq_stream_if.sv =====
interface afhq_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/accel_frame_health_qualifier.sv =====
// A frame passes the input register and then the result register on its way out.
// Throughput: one frame per cycle unless result_o stalls; the per-frame check,
// unpack and counter update is one logic pass between input and result registers.
// Reset: asynchronous, active low; clears both valid bits, the check slot,
// good-frame wait, hold-off deadline and error counter, and returns the config
// registers to their defaults.
module accel_frame_health_qualifier #(
  parameter int CHECK_SLOTS = afhq_pkg::CheckSlotsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  afhq_stream_if.sink   cfg_i,
  afhq_stream_if.sink   frame_i,
  afhq_stream_if.source result_o
);

  localparam int SlotW = (CHECK_SLOTS > 1) ? $clog2(CHECK_SLOTS) : 1;
  localparam int ExtW  = SlotW + 2;

  logic [7:0] exp_chip_id_q, exp_conf_q, exp_range_q, nd_mask_q;

  logic                          s_valid_q;
  afhq_pkg::frame_t              s_q;
  logic                          out_valid_q;
  afhq_pkg::result_t             res_q, res_d;

  logic [afhq_pkg::WaitW-1:0]    good_wait_q, good_wait_d;
  logic [SlotW-1:0]              slot_q, slot_d;
  logic [afhq_pkg::TimeW-1:0]    deadline_q, deadline_d;
  logic [afhq_pkg::ErrW-1:0]     err_q, err_d;

  logic advance, accept;

  assign cfg_i.ready     = 1'b1;
  assign advance         = s_valid_q && (!out_valid_q || result_o.ready);
  assign frame_i.ready   = !s_valid_q || advance;
  assign accept          = frame_i.valid && frame_i.ready;
  assign result_o.valid  = out_valid_q;
  assign result_o.payload = res_q;

  function automatic logic [afhq_pkg::TimeW-1:0] sat_add(
    input logic [afhq_pkg::TimeW-1:0] a,
    input logic [afhq_pkg::TimeW-1:0] b
  );
    logic [afhq_pkg::TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[afhq_pkg::TimeW] ? '1 : s[afhq_pkg::TimeW-1:0];
  endfunction

  function automatic logic [afhq_pkg::ErrW-1:0] sat_inc(
    input logic [afhq_pkg::ErrW-1:0] v
  );
    return (v == '1) ? v : v + afhq_pkg::ErrW'(1);
  endfunction

  always_comb begin
    logic [SlotW-1:0]          slot;
    logic [SlotW:0]            slot_inc;
    logic [ExtW-1:0]           slot_ext;
    logic [ExtW-1:0]           next_ext;
    logic [7:0]                expected;
    logic                      mismatch;
    logic [15:0]               wx, wy, wz;
    logic [afhq_pkg::AxisW-1:0] x, y, z;
    logic [afhq_pkg::WaitW-1:0] gw;

    good_wait_d = good_wait_q;
    slot_d      = slot_q;
    deadline_d  = deadline_q;
    err_d       = err_q;
    slot_inc    = '0;

    res_d             = '0;
    res_d.status      = afhq_pkg::StHeld;
    res_d.fix_action  = afhq_pkg::FixNone;

    slot = slot_q;
    if ({1'b0, slot_q} >= (SlotW+1)'(CHECK_SLOTS)) begin
      slot = '0;
    end
    slot_ext = ExtW'(slot);
    if (slot_ext == ExtW'(afhq_pkg::SlotChipId)) begin
      expected = exp_chip_id_q;
    end else if (slot_ext == ExtW'(afhq_pkg::SlotConf)) begin
      expected = exp_conf_q;
    end else if (slot_ext == ExtW'(afhq_pkg::SlotRange)) begin
      expected = exp_range_q;
    end else begin
      expected = '0;
    end
    mismatch = (s_q.check_readback != expected);

    wx = {s_q.x_high, s_q.x_low};
    wy = {s_q.y_high, s_q.y_low};
    wz = {s_q.z_high, s_q.z_low};
    x  = wx[afhq_pkg::AxisLsb +: afhq_pkg::AxisW];
    y  = wy[afhq_pkg::AxisLsb +: afhq_pkg::AxisW];
    z  = wz[afhq_pkg::AxisLsb +: afhq_pkg::AxisW];
    gw = good_wait_q;

    if (s_q.now_us < deadline_q) begin
      res_d.status = afhq_pkg::StHeld;
    end else if (!s_q.transfer_ok) begin
      res_d.status = afhq_pkg::StXferFail;
    end else begin
      if (mismatch) begin
        err_d = sat_inc(err_d);
        if (good_wait_q == '0 || slot == '0) begin
          res_d.fix_action = afhq_pkg::FixSoftReset;
          deadline_d       = sat_add(s_q.now_us, afhq_pkg::ResetHoldoffUs);
          slot             = '0;
        end else begin
          res_d.fix_action = afhq_pkg::FixRewrite;
          res_d.fix_slot   = slot_ext[1:0];
          res_d.fix_value  = expected;
          deadline_d       = sat_add(s_q.now_us, afhq_pkg::RewriteHoldoffUs);
        end
        gw = afhq_pkg::GoodWaitFrames;
      end
      slot_inc = {1'b0, slot} + (SlotW+1)'(1);
      if (slot_inc == (SlotW+1)'(CHECK_SLOTS)) begin
        slot_d = '0;
      end else begin
        slot_d = slot_inc[SlotW-1:0];
      end

      if ((s_q.x_low & nd_mask_q) == '0 || (s_q.y_low & nd_mask_q) == '0 ||
          (s_q.z_low & nd_mask_q) == '0) begin
        res_d.status = afhq_pkg::StDuplicate;
      end else if (x == '0 && y == '0 && z == '0) begin
        err_d        = sat_inc(err_d);
        res_d.status = afhq_pkg::StAllZero;
      end else if (gw != '0) begin
        gw           = gw - afhq_pkg::WaitW'(1);
        res_d.status = afhq_pkg::StSuppressed;
      end else begin
        res_d.status  = afhq_pkg::StValid;
        res_d.accel_x = x;
        res_d.accel_y = y;
        res_d.accel_z = z;
      end
      good_wait_d = gw;
    end

    next_ext          = ExtW'(slot_d);
    res_d.error_total = err_d;
    res_d.next_slot   = next_ext[1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_chip_id_q <= '0;
      exp_conf_q    <= '0;
      exp_range_q   <= '0;
      nd_mask_q     <= 8'd1;
    end else if (cfg_i.valid) begin
      unique case (afhq_pkg::cfg_reg_e'(cfg_i.payload.index))
        afhq_pkg::CfgChipId:      exp_chip_id_q <= cfg_i.payload.data;
        afhq_pkg::CfgConf:        exp_conf_q    <= cfg_i.payload.data;
        afhq_pkg::CfgRange:       exp_range_q   <= cfg_i.payload.data;
        afhq_pkg::CfgNewDataMask: nd_mask_q     <= cfg_i.payload.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      good_wait_q <= '0;
      slot_q      <= '0;
      deadline_q  <= '0;
      err_q       <= '0;
    end else begin
      s_valid_q   <= accept || (s_valid_q && !advance);
      out_valid_q <= advance || (out_valid_q && !result_o.ready);
      if (advance) begin
        good_wait_q <= good_wait_d;
        slot_q      <= slot_d;
        deadline_q  <= deadline_d;
        err_q       <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q <= frame_i.payload;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== tb/accel_frame_health_qualifier_tb.sv =====
module accel_frame_health_qualifier_tb;
  import afhq_pkg::*;

  localparam int CheckSlots = CheckSlotsDefault;
  localparam int CycleLimit = 400_000;

  class qualifier_scoreboard;
    logic [7:0] exp_reg [3];
    logic [7:0] nd_mask;
    logic [WaitW-1:0] good_wait;
    logic [1:0] slot;
    logic [TimeW-1:0] deadline;
    logic [ErrW-1:0] err_cnt;
    result_t due_results [$];
    int mismatches;
    int frames;
    int status_seen [6];
    int soft_resets;
    int rewrites;

    function new();
      exp_reg = '{8'h00, 8'h00, 8'h00};
      nd_mask = 8'h01;
      good_wait = '0;
      slot = '0;
      deadline = '0;
      err_cnt = '0;
      mismatches = 0;
      frames = 0;
      soft_resets = 0;
      rewrites = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void apply_config(cfg_reg_e idx, logic [7:0] d);
      case (idx)
        CfgChipId: exp_reg[SlotChipId] = d;
        CfgConf: exp_reg[SlotConf] = d;
        CfgRange: exp_reg[SlotRange] = d;
        CfgNewDataMask: nd_mask = d;
        default: ;
      endcase
    endfunction

    function logic [7:0] reg_for_slot(int unsigned s);
      case (s)
        SlotChipId: return exp_reg[SlotChipId];
        SlotConf: return exp_reg[SlotConf];
        SlotRange: return exp_reg[SlotRange];
        default: return 8'h00;
      endcase
    endfunction

    function int unsigned live_slot();
      return (slot >= CheckSlots) ? 0 : slot;
    endfunction

    function logic [7:0] due_readback();
      return reg_for_slot(live_slot());
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function logic [TimeW-1:0] sat_add(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
      logic [TimeW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TimeW] ? '1 : s[TimeW-1:0];
    endfunction

    function logic [AxisW-1:0] unpack(logic [7:0] lo, logic [7:0] hi);
      logic [15:0] w;
      w = {hi, lo};
      return w[AxisLsb +: AxisW];
    endfunction

    function void bump_errors();
      if (err_cnt != '1) err_cnt++;
    endfunction

    function void note_frame(frame_t f);
      result_t r;
      int unsigned s;
      logic [AxisW-1:0] x, y, z;
      r = '0;
      r.status = StHeld;
      r.fix_action = FixNone;
      if (f.now_us < deadline) begin
        r.status = StHeld;
      end else if (!f.transfer_ok) begin
        r.status = StXferFail;
      end else begin
        s = live_slot();
        if (f.check_readback != reg_for_slot(s)) begin
          bump_errors();
          if (good_wait == 0 || s == 0) begin
            r.fix_action = FixSoftReset;
            deadline = sat_add(f.now_us, ResetHoldoffUs);
            s = 0;
            soft_resets++;
          end else begin
            r.fix_action = FixRewrite;
            r.fix_slot = s[1:0];
            r.fix_value = reg_for_slot(s);
            deadline = sat_add(f.now_us, RewriteHoldoffUs);
            rewrites++;
          end
          good_wait = GoodWaitFrames;
        end
        slot = 2'((s + 1) % CheckSlots);
        x = unpack(f.x_low, f.x_high);
        y = unpack(f.y_low, f.y_high);
        z = unpack(f.z_low, f.z_high);
        if ((f.x_low & nd_mask) == 0 || (f.y_low & nd_mask) == 0 ||
            (f.z_low & nd_mask) == 0) begin
          r.status = StDuplicate;
        end else if (x == 0 && y == 0 && z == 0) begin
          bump_errors();
          r.status = StAllZero;
        end else if (good_wait != 0) begin
          good_wait--;
          r.status = StSuppressed;
        end else begin
          r.status = StValid;
          r.accel_x = x;
          r.accel_y = y;
          r.accel_z = z;
        end
      end
      r.error_total = err_cnt;
      r.next_slot = slot;
      status_seen[r.status]++;
      frames++;
      due_results.push_back(r);
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("mismatch %s: got %0h, want %0h", field, got, want);
    endtask

    task check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report("result without a pending frame", got.status, 0);
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.accel_x !== want.accel_x) report("accel_x", got.accel_x, want.accel_x);
      if (got.accel_y !== want.accel_y) report("accel_y", got.accel_y, want.accel_y);
      if (got.accel_z !== want.accel_z) report("accel_z", got.accel_z, want.accel_z);
      if (got.fix_action !== want.fix_action)
        report("fix_action", got.fix_action, want.fix_action);
      if (got.fix_slot !== want.fix_slot) report("fix_slot", got.fix_slot, want.fix_slot);
      if (got.fix_value !== want.fix_value)
        report("fix_value", got.fix_value, want.fix_value);
      if (got.error_total !== want.error_total)
        report("error_total", got.error_total, want.error_total);
      if (got.next_slot !== want.next_slot)
        report("next_slot", got.next_slot, want.next_slot);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit steady;
  int cycles;
  logic [TimeW-1:0] now_us;
  qualifier_scoreboard sb;

  afhq_stream_if #(.payload_t(cfg_t)) cfg_if ();
  afhq_stream_if #(.payload_t(frame_t)) frame_if ();
  afhq_stream_if #(.payload_t(result_t)) result_if ();

  accel_frame_health_qualifier #(
    .CHECK_SLOTS(CheckSlots)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_i(cfg_if),
    .frame_i(frame_if),
    .result_o(result_if)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // check before noting so a same-edge request never meets its own result
  always @(posedge clk_i) begin
    cycles++;
    if (result_if.valid && result_if.ready) sb.check_result(result_if.payload);
    if (frame_if.valid && frame_if.ready) sb.note_frame(frame_if.payload);
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    result_if.ready = steady || ($urandom_range(0, 99) >= 10);
  end

  function automatic frame_t make_frame(logic [TimeW-1:0] t, bit ok,
                                        logic [7:0] xl, logic [7:0] xh,
                                        logic [7:0] yl, logic [7:0] yh,
                                        logic [7:0] zl, logic [7:0] zh,
                                        logic [7:0] rb);
    frame_t f;
    f.now_us = t;
    f.transfer_ok = ok;
    f.x_low = xl;
    f.x_high = xh;
    f.y_low = yl;
    f.y_high = yh;
    f.z_low = zl;
    f.z_high = zh;
    f.check_readback = rb;
    return f;
  endfunction

  function automatic frame_t random_frame(logic [TimeW-1:0] t);
    logic [7:0] lo [3];
    logic [7:0] hi [3];
    logic [7:0] m;
    logic [7:0] rb;
    bit zero_axes;
    m = sb.nd_mask;
    zero_axes = ($urandom_range(0, 99) < 5);
    for (int i = 0; i < 3; i++) begin
      if (zero_axes) begin
        hi[i] = 8'h00;
        lo[i] = 8'($urandom_range(0, 15)) | (m & 8'h0F);
      end else begin
        hi[i] = 8'($urandom);
        lo[i] = ($urandom_range(0, 99) < 5) ? 8'($urandom) : (8'($urandom) | m);
      end
    end
    rb = sb.due_readback();
    if ($urandom_range(0, 99) < 3) rb ^= 8'($urandom_range(1, 255));
    return make_frame(t, $urandom_range(0, 99) >= 4, lo[0], hi[0], lo[1], hi[1],
                      lo[2], hi[2], rb);
  endfunction

  function automatic logic [TimeW-1:0] time_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return TimeW'($urandom_range(0, 800));
    if (r < 85) return TimeW'($urandom_range(800, 4000));
    if (r < 97) return TimeW'($urandom_range(4000, 12000));
    return '0;
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_frame(frame_t f);
    while (!steady && $urandom_range(0, 99) < 10) begin
      frame_if.valid = 1'b0;
      @(negedge clk_i);
    end
    frame_if.valid = 1'b1;
    frame_if.payload = f;
    @(posedge clk_i);
    while (!frame_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    frame_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [7:0] d);
    cfg_if.valid = 1'b1;
    cfg_if.payload.index = idx;
    cfg_if.payload.data = d;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.apply_config(idx, d);
    @(negedge clk_i);
  endtask

  task automatic set_config(logic [7:0] chip, logic [7:0] conf, logic [7:0] rng,
                            logic [7:0] mask);
    cfg_write(CfgChipId, chip);
    cfg_write(CfgConf, conf);
    cfg_write(CfgRange, rng);
    cfg_write(CfgNewDataMask, mask);
    cfg_if.valid = 1'b0;
  endtask

  task automatic directed_frame(logic [TimeW-1:0] t, bit ok,
                                logic [7:0] xl, logic [7:0] xh,
                                logic [7:0] yl, logic [7:0] yh,
                                logic [7:0] zl, logic [7:0] zh, bit bad);
    now_us = t;
    send_frame(make_frame(t, ok, xl, xh, yl, yh, zl, zh,
                          sb.due_readback() ^ (bad ? 8'hA5 : 8'h00)));
  endtask

  task automatic run_random(int n, bit quiet);
    int pause_at;
    steady = quiet;
    pause_at = $urandom_range(n / 4, 3 * n / 4);
    now_us += TimeW'({32'h0, $urandom} << $urandom_range(0, 28));
    for (int i = 0; i < n; i++) begin
      // hold off until the block has emptied
      if (i == pause_at) drain();
      now_us += time_step();
      send_frame(random_frame(now_us));
    end
    steady = 1'b0;
  endtask

  initial begin
    sb = new();
    cycles = 0;
    steady = 1'b0;
    now_us = '0;
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
    frame_if.valid = 1'b0;
    frame_if.payload = '0;
    result_if.ready = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset configuration: axis extremes, each rejection, each repair
    directed_frame(64'd100, 1, 8'hF1, 8'h7F, 8'h01, 8'h80, 8'h01, 8'h00, 0);
    directed_frame(64'd150, 1, 8'hFF, 8'hFF, 8'h11, 8'h00, 8'h21, 8'h12, 0);
    directed_frame(64'd200, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1);
    directed_frame(64'd250, 1, 8'h00, 8'h12, 8'h01, 8'h34, 8'h01, 8'h56, 0);
    directed_frame(64'd300, 1, 8'h01, 8'h12, 8'h00, 8'h34, 8'h01, 8'h56, 0);
    directed_frame(64'd350, 1, 8'h01, 8'h12, 8'h01, 8'h34, 8'hFE, 8'h56, 0);
    directed_frame(64'd400, 1, 8'h0F, 8'h00, 8'h01, 8'h00, 8'h09, 8'h00, 0);
    directed_frame(64'd500, 1, 8'h31, 8'h01, 8'h41, 8'h02, 8'h51, 8'h03, 1);
    directed_frame(64'd5000, 1, 8'h31, 8'h01, 8'h41, 8'h02, 8'h51, 8'h03, 0);
    directed_frame(64'd10499, 1, 8'h31, 8'h01, 8'h41, 8'h02, 8'h51, 8'h03, 0);
    directed_frame(64'd10500, 1, 8'h31, 8'h01, 8'h41, 8'h02, 8'h51, 8'h03, 0);
    directed_frame(64'd10600, 1, 8'h31, 8'h01, 8'h41, 8'h02, 8'h51, 8'h03, 1);
    directed_frame(64'd13599, 1, 8'h31, 8'h01, 8'h41, 8'h02, 8'h51, 8'h03, 0);
    directed_frame(64'd13600, 1, 8'h31, 8'h01, 8'h41, 8'h02, 8'h51, 8'h03, 0);
    directed_frame(64'd13700, 1, 8'h31, 8'h01, 8'h41, 8'h02, 8'h51, 8'h03, 1);
    directed_frame(64'd16700, 1, 8'h31, 8'h01, 8'h41, 8'h02, 8'h51, 8'h03, 1);
    drain();

    set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'h01);
    run_random(330, 0);
    drain();
    set_config(8'hFF, 8'h00, 8'hFF, 8'hFF);
    run_random(300, 1);
    drain();
    set_config(8'h00, 8'hFF, 8'h00, 8'h00);
    run_random(80, 0);
    drain();
    set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'h80);
    run_random(330, 0);
    drain();
    set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_random(330, 0);
    drain();
    set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'h10);
    run_random(330, 0);

    // top of the time range: the hold-off deadline saturates
    directed_frame('1 - 64'd2000, 1, 8'hFF, 8'h12, 8'hFF, 8'h34, 8'hFF, 8'h56, 0);
    directed_frame('1 - 64'd2000, 1, 8'hFF, 8'h12, 8'hFF, 8'h34, 8'hFF, 8'h56, 1);
    directed_frame('1 - 64'd1, 1, 8'hFF, 8'h12, 8'hFF, 8'h34, 8'hFF, 8'h56, 0);
    directed_frame('1, 1, 8'hFF, 8'h12, 8'hFF, 8'h34, 8'hFF, 8'h56, 1);
    directed_frame('1, 1, 8'hFF, 8'h12, 8'hFF, 8'h34, 8'hFF, 8'h56, 0);
    frame_if.valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (sb.pending() != 0) sb.report("results never arrived", sb.pending(), 0);

    $display("%0d frames: held %0d, transfer failed %0d, duplicate %0d, all zero %0d,",
             sb.frames, sb.status_seen[StHeld], sb.status_seen[StXferFail],
             sb.status_seen[StDuplicate], sb.status_seen[StAllZero]);
    $display("  suppressed %0d, valid %0d; soft resets %0d, rewrites %0d, error total %0d",
             sb.status_seen[StSuppressed], sb.status_seen[StValid], sb.soft_resets,
             sb.rewrites, sb.err_cnt);
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
